@@ hw/rtl/nts_pkg.sv @@
// Shared types and constants for the noise texture shaper.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package nts_pkg;

   // Fixed-point format of samples and shaped values (signed Q2.14).
   localparam int FRAC_BITS = 14;
   localparam int SW        = 16;
   localparam int ONE_INT   = 1 << FRAC_BITS;
   localparam int TW        = FRAC_BITS + 1;        // fog curve operand width
   localparam int HB        = FRAC_BITS + 1;        // phase bits that survive the shift
   localparam int PHASE_SHIFT = 31 - FRAC_BITS;

   localparam int COL_W    = 11;
   localparam int ROW_W    = 11;
   localparam int MODE_W   = 3;
   localparam int PERIOD_W = 11;
   localparam int GAIN_W   = 16;
   localparam int GREY_W   = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Noise gain is Q8.8.
   localparam int GAIN_FRAC = 8;

   // Radius is taken as floor(sqrt(d2) * 2^16).
   localparam int SQRT_SHIFT = 32;

   localparam logic [MODE_W-1:0] MODE_NONE   = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FOG    = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FIRE   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_MARBLE = 3'd3;
   localparam logic [MODE_W-1:0] MODE_WOOD   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] CSR_SHAPE_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STRIPE_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_GAIN    = 2'd2;

   localparam logic [MODE_W-1:0]   MODE_RESET   = MODE_NONE;
   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 11'd64;
   localparam logic [GAIN_W-1:0]   GAIN_RESET   = 16'd256;

   // CORDIC: Q1.30 datapath, angles in units of 2^-32 turn.
   localparam int CORDIC_STEPS = 24;
   localparam int CZW          = 34;
   localparam int Y_SHIFT      = 30 - FRAC_BITS;
   localparam logic signed [CZW-1:0] CORDIC_X0 = 34'sd652032874;
   localparam logic [0:CORDIC_STEPS-1][31:0] ATAN_TURNS = {
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   localparam int QUEUE_DEPTH = 2;
   localparam int QPW = 1;
   localparam int QCW = 2;

   typedef enum logic [2:0] {
      CLS_PASS,
      CLS_FOG,
      CLS_FIRE,
      CLS_MARBLE,
      CLS_WOOD
   } nts_cls_type;

   typedef struct packed {
      logic [COL_W-1:0]     col;
      logic [ROW_W-1:0]     row;
      logic signed [SW-1:0] v;
      nts_cls_type          cls;
   } nts_item_type;

   // Carried alongside the radius / divide stages.
   typedef struct packed {
      logic                 sine;
      logic                 wood;
      logic signed [SW-1:0] s_pre;
      logic [HB-1:0]        noise;
      logic [COL_W-1:0]     col;
   } nts_side_type;

   // Carried alongside the CORDIC stages.
   typedef struct packed {
      logic                 valid;
      logic                 sine;
      logic                 flip;
      logic signed [SW-1:0] s_pre;
   } nts_tag_type;

endpackage

`default_nettype wire

@@ hw/rtl/nts_front.sv @@
// Front end: accepts a sample, clamps it and classifies it by shape mode.
// Depends on nts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nts_front import nts_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [COL_W-1:0]     req_pixel_col,
   input  wire logic [ROW_W-1:0]     req_pixel_row,
   input  wire logic signed [SW-1:0] req_noise_sample,
   input  wire logic [MODE_W-1:0]    shape_mode,
   input  wire logic                 q_full,
   output logic                      push,
   output nts_item_type              item
);

   localparam logic signed [SW-1:0] ONE_S = SW'(ONE_INT);

   logic         vld_ff;
   logic         vld_in;
   nts_item_type item_ff;
   nts_item_type item_in;
   logic         accept;

   assign req_ready = !vld_ff || !q_full;
   assign push      = vld_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign item      = item_ff;

   always_comb begin
      item_in.col = req_pixel_col;
      item_in.row = req_pixel_row;
      if (req_noise_sample > ONE_S) begin
         item_in.v = ONE_S;
      end else if (req_noise_sample < -ONE_S) begin
         item_in.v = -ONE_S;
      end else begin
         item_in.v = req_noise_sample;
      end
      unique case (shape_mode)
         MODE_FOG:    item_in.cls = CLS_FOG;
         MODE_FIRE:   item_in.cls = CLS_FIRE;
         MODE_MARBLE: item_in.cls = CLS_MARBLE;
         MODE_WOOD:   item_in.cls = CLS_WOOD;
         default:     item_in.cls = CLS_PASS;   // none and unused codes
      endcase
   end

   always_comb begin
      if (accept) begin
         vld_in = 1'b1;
      end else if (push) begin
         vld_in = 1'b0;
      end else begin
         vld_in = vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/nts_queue.sv @@
// Two-entry queue between the front end and the arithmetic pipeline.
// Depends on nts_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nts_queue import nts_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   push,
   input  nts_item_type push_item,
   input  wire logic   pop,
   output logic        head_valid,
   output nts_item_type head_item,
   output logic        full
);

   nts_item_type     slot_ff [QUEUE_DEPTH];
   logic [QPW-1:0]   rd_ptr_ff;
   logic [QPW-1:0]   wr_ptr_ff;
   logic [QCW-1:0]   count_ff;
   logic [QCW-1:0]   count_in;
   logic             do_pop;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == QCW'(QUEUE_DEPTH));
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/nts_cordic.sv @@
// Pipelined CORDIC sine, one rotation step per stage.
// Depends on nts_pkg for the angle table and tag type.
`timescale 1ns / 1ps
`default_nettype none

module nts_cordic import nts_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic signed [CZW-1:0] z_in,
   input  nts_tag_type                tag_in,
   output logic signed [CZW-1:0]      y_out,
   output nts_tag_type                tag_out
);

   logic signed [CZW-1:0] x_ff [CORDIC_STEPS];
   logic signed [CZW-1:0] y_ff [CORDIC_STEPS];
   logic signed [CZW-1:0] z_ff [CORDIC_STEPS];
   nts_tag_type           tag_ff [CORDIC_STEPS];

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [CZW-1:0] xi;
      logic signed [CZW-1:0] yi;
      logic signed [CZW-1:0] zi;
      nts_tag_type           ti;
      logic signed [CZW-1:0] dxs;
      logic signed [CZW-1:0] dys;
      logic signed [CZW-1:0] at;

      if (i == 0) begin : g_first
         assign xi = CORDIC_X0;
         assign yi = '0;
         assign zi = z_in;
         assign ti = tag_in;
      end else begin : g_next
         assign xi = x_ff[i-1];
         assign yi = y_ff[i-1];
         assign zi = z_ff[i-1];
         assign ti = tag_ff[i-1];
      end

      assign dxs = yi >>> i;
      assign dys = xi >>> i;
      assign at  = $signed({{(CZW-32){1'b0}}, ATAN_TURNS[i]});

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[i] <= '0;
         end else if (en) begin
            tag_ff[i] <= ti;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (!zi[CZW-1]) begin
               x_ff[i] <= xi - dxs;
               y_ff[i] <= yi + dys;
               z_ff[i] <= zi - at;
            end else begin
               x_ff[i] <= xi + dxs;
               y_ff[i] <= yi - dys;
               z_ff[i] <= zi + at;
            end
         end
      end
   end

   assign y_out   = y_ff[CORDIC_STEPS-1];
   assign tag_out = tag_ff[CORDIC_STEPS-1];

endmodule

`default_nettype wire

@@ hw/rtl/nts_back.sv @@
// Arithmetic pipeline: fog curve, radius square root, position divide,
// phase fold, CORDIC sine and the output register. Depends on nts_pkg, nts_cordic.
`timescale 1ns / 1ps
`default_nettype none

module nts_back import nts_pkg::*; #(
   parameter int IMAGE_SIZE = 2048
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_valid,
   input  nts_item_type              q_item,
   output logic                      q_pop,
   input  wire logic [PERIOD_W-1:0]  period,
   input  wire logic [GAIN_W-1:0]    gain,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic signed [SW-1:0]      rsp_shaped_value,
   output logic [GREY_W-1:0]         rsp_grey_level
);

   localparam int CW  = $clog2(IMAGE_SIZE);
   localparam int DW  = ((CW > COL_W) ? CW : COL_W) + 2;
   localparam int D2W = 2 * DW - 1;
   localparam int SQ  = (D2W + SQRT_SHIFT + 1) / 2;
   localparam int PD  = 2 * SQ - SQRT_SHIFT;
   localparam int RW  = SQ + 2;
   localparam int MW  = COL_W + FRAC_BITS;
   localparam int NW  = (SQ > MW) ? SQ : MW;
   localparam int DVW = PERIOD_W + 2;
   localparam int PW  = SW + GAIN_W + 1;
   localparam int FW  = TW + 6;
   localparam int YW  = CZW - Y_SHIFT;
   localparam logic [DW-1:0] CENTER = DW'(IMAGE_SIZE / 2);
   localparam logic signed [FW-1:0] ONE_F = FW'(ONE_INT);
   localparam logic signed [FW-1:0] K6  = FW'(6);
   localparam logic signed [FW-1:0] K15 = FW'(15);
   localparam logic signed [FW-1:0] K10 = FW'(10);
   localparam logic signed [YW-1:0] ONE_Y = YW'(ONE_INT);
   localparam logic [SW:0] ONE_U = (SW+1)'(ONE_INT);

   logic adv;
   logic rsp_valid_ff;
   logic signed [SW-1:0] rsp_shaped_ff;
   logic [GREY_W-1:0]    rsp_grey_ff;

   // the whole pipeline moves whenever the output slot can take a result
   assign adv   = !rsp_valid_ff || rsp_ready;
   assign q_pop = adv;

   // ---------------- stage 1: offsets, noise product, fog operand
   logic                 p1_vld_ff;
   logic signed [DW-1:0] p1_dx_ff, p1_dy_ff;
   logic signed [PW-1:0] p1_prod_ff;
   logic [TW-1:0]        p1_t_ff;
   logic signed [SW-1:0] p1_v_ff;
   nts_cls_type          p1_cls_ff;
   logic [COL_W-1:0]     p1_col_ff;
   logic [SW:0]          vpos;

   assign vpos = (SW+1)'(q_item.v) + ONE_U;

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_dx_ff   <= $signed(DW'(q_item.col) - CENTER);
         p1_dy_ff   <= $signed(DW'(q_item.row) - CENTER);
         p1_prod_ff <= q_item.v * $signed({1'b0, gain});
         p1_t_ff    <= vpos[TW:1];
         p1_v_ff    <= q_item.v;
         p1_cls_ff  <= q_item.cls;
         p1_col_ff  <= q_item.col;
      end
   end

   // ---------------- stage 2: squares, t^2
   logic                 p2_vld_ff;
   logic [D2W-1:0]       p2_dxx_ff, p2_dyy_ff;
   logic [TW-1:0]        p2_t_ff, p2_t2_ff;
   logic [HB-1:0]        p2_noise_ff;
   logic signed [SW-1:0] p2_v_ff;
   nts_cls_type          p2_cls_ff;
   logic [COL_W-1:0]     p2_col_ff;
   logic signed [2*DW-1:0] dxx_full, dyy_full;
   logic [2*TW-1:0]      tt_full;

   assign dxx_full = p1_dx_ff * p1_dx_ff;
   assign dyy_full = p1_dy_ff * p1_dy_ff;
   assign tt_full  = p1_t_ff * p1_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p2_dxx_ff   <= dxx_full[D2W-1:0];
         p2_dyy_ff   <= dyy_full[D2W-1:0];
         p2_t_ff     <= p1_t_ff;
         p2_t2_ff    <= tt_full[2*FRAC_BITS:FRAC_BITS];
         p2_noise_ff <= p1_prod_ff[HB+GAIN_FRAC-1:GAIN_FRAC];   // floor(v*gain/256)
         p2_v_ff     <= p1_v_ff;
         p2_cls_ff   <= p1_cls_ff;
         p2_col_ff   <= p1_col_ff;
      end
   end

   // ---------------- stage 3: d2, t^3
   logic                 p3_vld_ff;
   logic [D2W-1:0]       p3_d2_ff;
   logic [TW-1:0]        p3_t_ff, p3_t3_ff;
   logic [HB-1:0]        p3_noise_ff;
   logic signed [SW-1:0] p3_v_ff;
   nts_cls_type          p3_cls_ff;
   logic [COL_W-1:0]     p3_col_ff;
   logic [2*TW-1:0]      t3_full;

   assign t3_full = p2_t2_ff * p2_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_d2_ff    <= p2_dxx_ff + p2_dyy_ff;
         p3_t_ff     <= p2_t_ff;
         p3_t3_ff    <= t3_full[2*FRAC_BITS:FRAC_BITS];
         p3_noise_ff <= p2_noise_ff;
         p3_v_ff     <= p2_v_ff;
         p3_cls_ff   <= p2_cls_ff;
         p3_col_ff   <= p2_col_ff;
      end
   end

   // ---------------- stage 4: t^4
   logic                 p4_vld_ff;
   logic [D2W-1:0]       p4_d2_ff;
   logic [TW-1:0]        p4_t_ff, p4_t3_ff, p4_t4_ff;
   logic [HB-1:0]        p4_noise_ff;
   logic signed [SW-1:0] p4_v_ff;
   nts_cls_type          p4_cls_ff;
   logic [COL_W-1:0]     p4_col_ff;
   logic [2*TW-1:0]      t4_full;

   assign t4_full = p3_t3_ff * p3_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p4_d2_ff    <= p3_d2_ff;
         p4_t_ff     <= p3_t_ff;
         p4_t3_ff    <= p3_t3_ff;
         p4_t4_ff    <= t4_full[2*FRAC_BITS:FRAC_BITS];
         p4_noise_ff <= p3_noise_ff;
         p4_v_ff     <= p3_v_ff;
         p4_cls_ff   <= p3_cls_ff;
         p4_col_ff   <= p3_col_ff;
      end
   end

   // ---------------- stage 5: t^5
   logic                 p5_vld_ff;
   logic [D2W-1:0]       p5_d2_ff;
   logic [TW-1:0]        p5_t3_ff, p5_t4_ff, p5_t5_ff;
   logic [HB-1:0]        p5_noise_ff;
   logic signed [SW-1:0] p5_v_ff;
   nts_cls_type          p5_cls_ff;
   logic [COL_W-1:0]     p5_col_ff;
   logic [2*TW-1:0]      t5_full;

   assign t5_full = p4_t4_ff * p4_t_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         p5_d2_ff    <= p4_d2_ff;
         p5_t3_ff    <= p4_t3_ff;
         p5_t4_ff    <= p4_t4_ff;
         p5_t5_ff    <= t5_full[2*FRAC_BITS:FRAC_BITS];
         p5_noise_ff <= p4_noise_ff;
         p5_v_ff     <= p4_v_ff;
         p5_cls_ff   <= p4_cls_ff;
         p5_col_ff   <= p4_col_ff;
      end
   end

   // ---------------- stage 6: shaped value for the non-sine modes
   logic                 p6_vld_ff;
   logic [D2W-1:0]       p6_d2_ff;
   nts_side_type         p6_side_ff;
   nts_side_type         side_in;
   logic signed [FW-1:0] f_raw, f_clamped, fog_s;
   logic signed [SW+1:0] v_abs, fire_s;

   always_comb begin
      f_raw = K6 * $signed(FW'(p5_t5_ff)) - K15 * $signed(FW'(p5_t4_ff))
            + K10 * $signed(FW'(p5_t3_ff));
      if (f_raw < 0) begin
         f_clamped = '0;
      end else if (f_raw > ONE_F) begin
         f_clamped = ONE_F;
      end else begin
         f_clamped = f_raw;
      end
      fog_s  = (f_clamped <<< 1) - ONE_F;
      v_abs  = p5_v_ff[SW-1] ? -(SW+2)'(p5_v_ff) : (SW+2)'(p5_v_ff);
      fire_s = (SW+2)'(ONE_INT) - (v_abs <<< 1);

      side_in.sine  = (p5_cls_ff == CLS_MARBLE) || (p5_cls_ff == CLS_WOOD);
      side_in.wood  = (p5_cls_ff == CLS_WOOD);
      side_in.noise = p5_noise_ff;
      side_in.col   = p5_col_ff;
      case (p5_cls_ff)
         CLS_FOG:  side_in.s_pre = fog_s[SW-1:0];
         CLS_FIRE: side_in.s_pre = fire_s[SW-1:0];
         default:  side_in.s_pre = p5_v_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p6_d2_ff   <= p5_d2_ff;
         p6_side_ff <= side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
         p5_vld_ff <= 1'b0;
         p6_vld_ff <= 1'b0;
      end else if (adv) begin
         p1_vld_ff <= q_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
         p5_vld_ff <= p4_vld_ff;
         p6_vld_ff <= p5_vld_ff;
      end
   end

   // ---------------- radius: one root bit per stage, floor(sqrt(d2 << 32))
   logic               sq_vld_ff  [SQ];
   logic [RW-1:0]      sq_rem_ff  [SQ];
   logic [SQ-1:0]      sq_root_ff [SQ];
   logic [PD-1:0]      sq_m_ff    [SQ];
   nts_side_type       sq_side_ff [SQ];

   for (genvar k = 0; k < SQ; k++) begin : g_sq
      localparam int P = SQ - 1 - k;
      logic          vld_i;
      logic [RW-1:0] rem_i;
      logic [SQ-1:0] root_i;
      logic [PD-1:0] m_i;
      nts_side_type  side_i;
      logic [1:0]    pair;
      logic [RW+1:0] r4, trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign vld_i  = p6_vld_ff;
         assign rem_i  = '0;
         assign root_i = '0;
         assign m_i    = PD'(p6_d2_ff);
         assign side_i = p6_side_ff;
      end else begin : g_next
         assign vld_i  = sq_vld_ff[k-1];
         assign rem_i  = sq_rem_ff[k-1];
         assign root_i = sq_root_ff[k-1];
         assign m_i    = sq_m_ff[k-1];
         assign side_i = sq_side_ff[k-1];
      end

      // low 32 bits of the radicand are zero
      if (P >= SQRT_SHIFT / 2) begin : g_pair
         assign pair = m_i[2*P-SQRT_SHIFT+1 -: 2];
      end else begin : g_zero
         assign pair = 2'b00;
      end

      assign r4    = {rem_i, pair};
      assign trial = {2'b00, root_i, 2'b01};
      assign ge    = (r4 >= trial);

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k]  <= ge ? RW'(r4 - trial) : RW'(r4);
            sq_root_ff[k] <= {root_i[SQ-2:0], ge};
            sq_m_ff[k]    <= m_i;
            sq_side_ff[k] <= side_i;
         end
      end
   end

   // ---------------- position: restoring divide, one quotient bit per stage
   logic [PERIOD_W-1:0] period_eff;
   logic                dv_vld_ff  [NW];
   logic [DVW-1:0]      dv_rem_ff  [NW];
   logic [HB-1:0]       dv_q_ff    [NW];
   logic [NW-1:0]       dv_n_ff    [NW];
   nts_side_type        dv_side_ff [NW];

   assign period_eff = (period == '0) ? PERIOD_W'(1) : period;

   for (genvar k = 0; k < NW; k++) begin : g_dv
      logic           vld_i;
      logic [DVW-1:0] rem_i;
      logic [HB-1:0]  q_i;
      logic [NW-1:0]  n_i;
      nts_side_type   side_i;
      logic [DVW-1:0] d;
      logic [DVW:0]   r2;
      logic           ge;

      if (k == 0) begin : g_first
         assign vld_i  = sq_vld_ff[SQ-1];
         assign rem_i  = '0;
         assign q_i    = '0;
         assign side_i = sq_side_ff[SQ-1];
         // wood divides r by 4*period, marble divides col<<F by period
         assign n_i    = side_i.wood ? NW'(sq_root_ff[SQ-1])
                                     : NW'({side_i.col, {FRAC_BITS{1'b0}}});
      end else begin : g_next
         assign vld_i  = dv_vld_ff[k-1];
         assign rem_i  = dv_rem_ff[k-1];
         assign q_i    = dv_q_ff[k-1];
         assign n_i    = dv_n_ff[k-1];
         assign side_i = dv_side_ff[k-1];
      end

      assign d  = side_i.wood ? {period_eff, 2'b00} : {2'b00, period_eff};
      assign r2 = {rem_i, n_i[NW-1-k]};
      assign ge = (r2 >= {1'b0, d});

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[k] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[k] <= vld_i;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_rem_ff[k]  <= ge ? DVW'(r2 - {1'b0, d}) : DVW'(r2);
            dv_q_ff[k]    <= {q_i[HB-2:0], ge};
            dv_n_ff[k]    <= n_i;
            dv_side_ff[k] <= side_i;
         end
      end
   end

   // ---------------- phase: sum and fold into the right half-plane
   logic [HB-1:0]         h_sum, h_fold;
   logic                  h_flip;
   logic signed [CZW-1:0] ph_z_ff;
   nts_tag_type           ph_tag_ff;
   nts_side_type          dv_last;

   assign dv_last = dv_side_ff[NW-1];
   assign h_sum   = dv_q_ff[NW-1] + dv_last.noise;
   assign h_flip  = h_sum[HB-1] ^ h_sum[HB-2];
   assign h_fold  = {h_sum[HB-1] ^ h_flip, h_sum[HB-2:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_tag_ff <= '0;
      end else if (adv) begin
         ph_tag_ff.valid <= dv_vld_ff[NW-1];
         ph_tag_ff.sine  <= dv_last.sine;
         ph_tag_ff.flip  <= h_flip;
         ph_tag_ff.s_pre <= dv_last.s_pre;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ph_z_ff <= $signed({{(CZW-32){h_fold[HB-1]}}, h_fold, {PHASE_SHIFT{1'b0}}});
      end
   end

   logic signed [CZW-1:0] cd_y;
   nts_tag_type           cd_tag;

   nts_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .en      (adv),
      .z_in    (ph_z_ff),
      .tag_in  (ph_tag_ff),
      .y_out   (cd_y),
      .tag_out (cd_tag)
   );

   // ---------------- output register
   logic signed [YW-1:0] yq, ys;
   logic signed [SW-1:0] sine_s, s_fin;
   logic [SW-1:0]        s_off;
   logic [SW+GREY_W-1:0] grey_full;

   always_comb begin
      yq = cd_y[CZW-1:Y_SHIFT];
      ys = cd_tag.flip ? -yq : yq;
      if (ys > ONE_Y) begin
         sine_s = SW'(ONE_INT);
      end else if (ys < -ONE_Y) begin
         sine_s = -SW'(ONE_INT);
      end else begin
         sine_s = ys[SW-1:0];
      end
      s_fin     = cd_tag.sine ? sine_s : cd_tag.s_pre;
      s_off     = SW'((SW+1)'(s_fin) + ONE_U);
      // *255 as a shift and subtract; never exceeds 255 after the >> (F+1)
      grey_full = ((SW+GREY_W)'(s_off) << GREY_W) - (SW+GREY_W)'(s_off);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= cd_tag.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_shaped_ff <= s_fin;
         rsp_grey_ff   <= grey_full[FRAC_BITS+GREY_W:FRAC_BITS+1];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_shaped_value = rsp_shaped_ff;
   assign rsp_grey_level   = rsp_grey_ff;

endmodule

`default_nettype wire

@@ hw/rtl/noise_texture_shaper_unit.sv @@
// Noise texture shaper: an accepted transaction passes the front-end register, queue
// write, 6 shaping stages, 29 root and 29 divide stages at IMAGE_SIZE 2048, phase
// stage, 24 CORDIC stages and the output register. Root and divide set the depth.
// Throughput one transaction per cycle while rsp_ready does not stall the pipeline.
// Synchronous active-high reset clears all valid flags and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module noise_texture_shaper_unit import nts_pkg::*; #(
   parameter int IMAGE_SIZE = 2048
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [COL_W-1:0]        req_pixel_col,
   input  wire logic [ROW_W-1:0]        req_pixel_row,
   input  wire logic signed [SW-1:0]    req_noise_sample,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [SW-1:0]         rsp_shaped_value,
   output logic [GREY_W-1:0]            rsp_grey_level,
   input  wire logic                    csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]    csr_index,
   input  wire logic [CSR_DATA_W-1:0]   csr_wdata
);

   logic [MODE_W-1:0]   mode_ff;
   logic [PERIOD_W-1:0] period_ff;
   logic [GAIN_W-1:0]   gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_RESET;
         period_ff <= PERIOD_RESET;
         gain_ff   <= GAIN_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_SHAPE_MODE:    mode_ff   <= csr_wdata[MODE_W-1:0];
            CSR_STRIPE_PERIOD: period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_NOISE_GAIN:    gain_ff   <= csr_wdata[GAIN_W-1:0];
            default: ;
         endcase
      end
   end

   logic         fe_push;
   nts_item_type fe_item;
   logic         q_full;
   logic         q_valid;
   nts_item_type q_item;
   logic         bk_pop;

   nts_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_pixel_col    (req_pixel_col),
      .req_pixel_row    (req_pixel_row),
      .req_noise_sample (req_noise_sample),
      .shape_mode       (mode_ff),
      .q_full           (q_full),
      .push             (fe_push),
      .item             (fe_item)
   );

   nts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (fe_push),
      .push_item  (fe_item),
      .pop        (bk_pop),
      .head_valid (q_valid),
      .head_item  (q_item),
      .full       (q_full)
   );

   nts_back #(
      .IMAGE_SIZE (IMAGE_SIZE)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (bk_pop),
      .period           (period_ff),
      .gain             (gain_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_shaped_value (rsp_shaped_value),
      .rsp_grey_level   (rsp_grey_level)
   );

   localparam logic signed [SW-1:0] ONE_S = SW'(ONE_INT);

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fe_push && q_full))
      else $error("queue push while full");

   a_back_flows: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> bk_pop)
      else $error("pipeline stalled with empty output slot");

   a_shaped_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_shaped_value <= ONE_S) && (rsp_shaped_value >= -ONE_S))
      else $error("shaped value out of range");

   // offset value is 0..2^(F+1), taken unsigned
   a_grey_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_grey_level ==
         GREY_W'((((SW+GREY_W)'($unsigned(SW'(rsp_shaped_value + ONE_S)))) * 255)
                 >> (FRAC_BITS + 1)))
      else $error("grey level does not match shaped value");

endmodule

`default_nettype wire
